### src/pts_pkg.sv
// Shared types, constants and codes for the priority thread scheduler.
package pts_pkg;

  localparam int DefNumSlots = 16;
  localparam int DefIdleSlot = 1;

  localparam logic [5:0] LAUNCHER_PRIO = 6'd16;
  localparam logic [5:0] IDLE_PRIO     = 6'd32;

  localparam logic [1:0] ST_READY      = 2'd0;
  localparam logic [1:0] ST_WAITING    = 2'd1;
  localparam logic [1:0] ST_TERMINATED = 2'd2;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_SETPRI = 3'd1;
  localparam logic [2:0] CMD_WAKE   = 3'd2;
  localparam logic [2:0] CMD_SLEEP  = 3'd3;
  localparam logic [2:0] CMD_EXIT   = 3'd4;
  localparam logic [2:0] CMD_LOCK   = 3'd5;
  localparam logic [2:0] CMD_UNLOCK = 3'd6;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;  // capture input beat, pick target
  localparam logic [3:0] OP_DECIDE    = 4'd2;  // validate, apply field updates
  localparam logic [3:0] OP_UL_START  = 4'd3;
  localparam logic [3:0] OP_UL_STEP   = 4'd4;
  localparam logic [3:0] OP_INS_START = 4'd5;
  localparam logic [3:0] OP_INS_STEP  = 4'd6;
  localparam logic [3:0] OP_FR_START  = 4'd7;
  localparam logic [3:0] OP_FR_STEP   = 4'd8;
  localparam logic [3:0] OP_FINISH    = 4'd9;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] slot;
    logic [5:0] new_priority;
    logic       in_interrupt;
  } pts_in_t;

  typedef struct packed {
    logic        switch_valid;
    logic [3:0]  from_slot;
    logic [3:0]  to_slot;
    logic        resched_pending;
    logic [31:0] thread_id;
    logic        status;
  } pts_out_t;

  typedef struct packed {
    logic [3:0] op;
  } pts_cmd_t;

  // What the controller must do after the decide step.
  typedef struct packed {
    logic need_unlink;
    logic need_insert;
    logic need_resched;
    logic walk_done;
  } pts_stat_t;

endpackage

### src/pts_datapath.sv
// Slot table, list walker and result register of the thread scheduler.
module pts_datapath #(
  parameter int NUM_SLOTS = pts_pkg::DefNumSlots,
  parameter int IDLE_SLOT = pts_pkg::DefIdleSlot
) (
  input  logic               clk,
  input  logic               rst,
  input  pts_pkg::pts_in_t   in_beat,
  input  pts_pkg::pts_cmd_t  cmd,
  output pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_out_t  result
);
  import pts_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);
  localparam logic [LW-1:0] IDLE_L = LW'(IDLE_SLOT);
  localparam bit HAS_IDLE = (IDLE_SLOT < NUM_SLOTS) && (IDLE_SLOT != 0);

  // Slot table
  logic [LW-1:0] next_link [NUM_SLOTS];
  logic [5:0]    slot_priority [NUM_SLOTS];
  logic [1:0]    slot_state [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_listed;
  logic [LW-1:0] list_head;
  logic [LW-1:0] running_slot;
  logic [31:0]   lock_count;
  logic          pending_flag;
  logic [31:0]   id_counter;

  // Per-item working registers
  pts_in_t       item;
  logic [LW-1:0] target;
  logic [LW-1:0] from;
  logic [LW-1:0] prev;
  logic [LW-1:0] cur;
  logic [LW:0]   steps;
  logic          found;
  logic          sw;
  logic          ignored;
  logic [31:0]   tid;
  logic          need_unlink, need_insert, need_resched;

  logic          cur_ok, tgt_ok, tgt_listed;
  logic [SW-1:0] cur_i, tgt_i, prev_i;
  logic          steps_left;

  assign cur_ok     = cur < NIL;
  assign cur_i      = cur[SW-1:0];
  assign tgt_ok     = target < NIL;
  assign tgt_i      = target[SW-1:0];
  assign prev_i     = prev[SW-1:0];
  assign tgt_listed = tgt_ok && slot_listed[tgt_i];
  assign steps_left = steps < (LW+1)'(NUM_SLOTS);

  // Walk termination per walk kind
  logic ul_done, ins_done, fr_done;
  assign ul_done  = !(cur_ok && cur != target && steps_left);
  assign ins_done = !(cur_ok && slot_priority[cur_i] < slot_priority[tgt_i] && steps_left);
  assign fr_done  = !(cur_ok && slot_state[cur_i] != ST_READY && steps_left);

  always_comb begin
    stat.need_unlink  = need_unlink;
    stat.need_insert  = need_insert;
    stat.need_resched = need_resched;
    unique case (cmd.op)
      OP_UL_STEP:  stat.walk_done = ul_done;
      OP_INS_STEP: stat.walk_done = ins_done;
      OP_FR_STEP:  stat.walk_done = fr_done;
      default:     stat.walk_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // launcher slot heads the list, idle slot follows it
      for (int i = 0; i < NUM_SLOTS; i++) begin
        next_link[i]     <= (i == 0 && HAS_IDLE) ? IDLE_L : NIL;
        slot_priority[i] <= (i == 0) ? LAUNCHER_PRIO :
                            (HAS_IDLE && i == IDLE_SLOT) ? IDLE_PRIO : 6'd0;
        slot_state[i]    <= (i == 0 || (HAS_IDLE && i == IDLE_SLOT)) ? ST_READY : ST_WAITING;
        slot_listed[i]   <= (i == 0 || (HAS_IDLE && i == IDLE_SLOT));
      end
      list_head    <= '0;
      running_slot <= '0;
      lock_count   <= '0;
      pending_flag <= 1'b0;
      id_counter   <= 32'd1;
      need_unlink  <= 1'b0;
      need_insert  <= 1'b0;
      need_resched <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          item    <= in_beat;
          from    <= running_slot;
          sw      <= 1'b0;
          ignored <= 1'b1;
          tid     <= '0;
          if (in_beat.command == CMD_SLEEP || in_beat.command == CMD_EXIT)
            target <= running_slot;
          else if (32'(in_beat.slot) < 32'(NUM_SLOTS))
            target <= LW'(in_beat.slot);
          else
            target <= NIL;
        end
        OP_DECIDE: begin
          need_unlink  <= 1'b0;
          need_insert  <= 1'b0;
          need_resched <= 1'b0;
          unique case (item.command)
            CMD_CREATE: if (tgt_ok && !slot_listed[tgt_i]) begin
              id_counter           <= id_counter + 32'd1;
              tid                  <= id_counter + 32'd1;
              slot_priority[tgt_i] <= item.new_priority;
              slot_state[tgt_i]    <= ST_WAITING;
              slot_listed[tgt_i]   <= 1'b1;
              need_insert          <= 1'b1;
              ignored              <= 1'b0;
            end
            CMD_SETPRI: if (tgt_listed && target != IDLE_L &&
                            slot_priority[tgt_i] != item.new_priority) begin
              need_unlink  <= 1'b1;
              need_insert  <= 1'b1;
              need_resched <= 1'b1;
              ignored      <= 1'b0;
            end
            CMD_WAKE, CMD_SLEEP: if (tgt_listed) begin
              slot_state[tgt_i] <= (item.command == CMD_WAKE) ? ST_READY : ST_WAITING;
              need_resched      <= 1'b1;
              ignored           <= 1'b0;
            end
            CMD_EXIT: if (tgt_listed && target != IDLE_L) begin
              slot_listed[tgt_i] <= 1'b0;
              slot_state[tgt_i]  <= ST_TERMINATED;
              need_unlink        <= 1'b1;
              need_resched       <= 1'b1;
              ignored            <= 1'b0;
            end
            CMD_LOCK: begin
              if (lock_count != 32'hFFFF_FFFF) lock_count <= lock_count + 32'd1;
              ignored <= 1'b0;
            end
            CMD_UNLOCK: begin
              if (lock_count != 32'd0) lock_count <= lock_count - 32'd1;
              ignored <= 1'b0;
            end
            default: ;
          endcase
        end
        OP_UL_START, OP_INS_START, OP_FR_START: begin
          prev  <= NIL;
          cur   <= list_head;
          steps <= '0;
          found <= 1'b0;
        end
        OP_UL_STEP: begin
          if (!ul_done) begin
            prev  <= cur;
            cur   <= next_link[cur_i];
            steps <= steps + 1'b1;
          end else begin
            // splice out; priority is written here for set priority
            if (cur == target) begin
              if (prev < NIL) next_link[prev_i] <= next_link[tgt_i];
              else list_head <= next_link[tgt_i];
              next_link[tgt_i] <= NIL;
            end
            if (item.command == CMD_SETPRI) slot_priority[tgt_i] <= item.new_priority;
          end
        end
        OP_INS_STEP: begin
          if (!ins_done) begin
            prev  <= cur;
            cur   <= next_link[cur_i];
            steps <= steps + 1'b1;
          end else if (prev < NIL) begin
            next_link[tgt_i]  <= next_link[prev_i];
            next_link[prev_i] <= target;
          end else begin
            next_link[tgt_i] <= list_head;
            list_head        <= target;
          end
        end
        OP_FR_STEP: begin
          if (!fr_done) begin
            cur   <= next_link[cur_i];
            steps <= steps + 1'b1;
          end else begin
            found <= cur_ok && slot_state[cur_i] == ST_READY;
          end
        end
        OP_FINISH: begin
          // reschedule decision using walk result
          if (need_resched && lock_count == 32'd0) begin
            if (item.in_interrupt) begin
              pending_flag <= 1'b1;
            end else begin
              pending_flag <= 1'b0;
              if (found && cur != running_slot) begin
                running_slot <= cur;
                sw           <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.switch_valid    = sw;
  assign result.from_slot       = 4'(from);
  assign result.to_slot         = 4'(running_slot);
  assign result.resched_pending = pending_flag;
  assign result.thread_id       = tid;
  assign result.status          = ignored;

`ifndef SYNTHESIS
  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    list_head <= NIL) else $error("list head out of range");
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    running_slot < NIL) else $error("running slot out of range");
  a_idle_listed: assert property (@(posedge clk) disable iff (rst)
    !HAS_IDLE || slot_listed[IDLE_L[SW-1:0]]) else $error("idle slot left the list");
`endif
endmodule

### src/pts_ctrl.sv
// Sequencing controller for the thread scheduler.
module pts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t  cmd
);
  import pts_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DECIDE = 4'd1, S_UL0 = 4'd2, S_UL = 4'd3,
                         S_IN0 = 4'd4, S_IN = 4'd5, S_FR0 = 4'd6, S_FR = 4'd7,
                         S_FIN = 4'd8, S_OUT = 4'd9;

  logic [3:0] state, state_next;

  assign in_stall  = !(state == S_IDLE);
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE; state_next = S_UL0;
      end
      S_UL0: begin
        if (stat.need_unlink) begin
          cmd.op = OP_UL_START; state_next = S_UL;
        end else state_next = S_IN0;
      end
      S_UL: begin
        cmd.op = OP_UL_STEP;
        if (stat.walk_done) state_next = S_IN0;
      end
      S_IN0: begin
        if (stat.need_insert) begin
          cmd.op = OP_INS_START; state_next = S_IN;
        end else state_next = S_FR0;
      end
      S_IN: begin
        cmd.op = OP_INS_STEP;
        if (stat.walk_done) state_next = S_FR0;
      end
      S_FR0: begin
        if (stat.need_resched) begin
          cmd.op = OP_FR_START; state_next = S_FR;
        end else state_next = S_FIN;
      end
      S_FR: begin
        cmd.op = OP_FR_STEP;
        if (stat.walk_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FINISH; state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

`ifndef SYNTHESIS
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("input open while result held");
`endif
endmodule

### src/priority_thread_scheduler_core.sv
// Order: every item is loaded and decided, then runs the unlink, insert and first-ready
// walks that it needs, then the finish step; lock, unlock and ignored items need no walk.
// One item at a time: a new item is taken only after the last result has left,
// since the single list walker over the slot table serves all walks.
// Reset (synchronous): slot 0 heads the list running, idle slot follows it.
// Top level of the thread scheduler: controller plus datapath.
module priority_thread_scheduler_core #(
  parameter int NUM_SLOTS = pts_pkg::DefNumSlots,
  parameter int IDLE_SLOT = pts_pkg::DefIdleSlot
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pts_pkg::pts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pts_pkg::pts_out_t out_data
);
  import pts_pkg::*;

  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  pts_datapath #(.NUM_SLOTS(NUM_SLOTS), .IDLE_SLOT(IDLE_SLOT)) u_dp (
    .clk(clk), .rst(rst), .in_beat(in_data), .cmd(cmd), .stat(stat), .result(out_data)
  );
endmodule
